// File: design/swfm_pkg.sv
// Shared constants for the sliding window frequency meter.
// No dependencies.
package swfm_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned STEP_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS      = 1'd1;

  localparam logic [15:0] WINDOW_MS_RESET = 16'd1000;
  localparam logic [15:0] WIN_MIN_MS      = 16'd10;
  localparam logic [15:0] WIN_CAP_MS      = 16'd2000;
  localparam logic [STEP_W-1:0] STEP_CAP  = 8'd200;

  // floor(w * TICK_RECIP / 2^16) equals w / 10 for every w up to WIN_CAP_MS
  localparam logic [12:0] TICK_RECIP = 13'd6554;
  localparam logic [9:0]  FREQ_SCALE = 10'd1000;

endpackage

// File: design/swfm_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module swfm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/sliding_window_frequency_meter_top.sv
// Top level of one sliding window frequency meter channel.
// Uses swfm_pkg and swfm_ram.
//
// Each request is one 10 ms tick. While measuring and running, the sampled count
// is stored in a ring of RING_DEPTH entries; once more than window_ms/10 samples
// (at least 1, at most 200) were taken since start, the result is the count
// difference over the window times 1000 divided by the window in ticks, in 0.1 Hz
// units, wrapping at 32 bits. A measured request goes from acceptance to the
// result register through the accepting cycle with its ring read, one subtract,
// one multiply, the bit-serial restoring divider and the load of the result
// register. Other requests go from acceptance straight to that load.
// The input is not ready while a request is in work; the next request may be
// accepted while a result still waits in the output register.
module sliding_window_frequency_meter_top #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [swfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swfm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [swfm_pkg::CNT_W-1:0]          in_count_sample,
  input  logic                                in_running,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_freq_valid,
  output logic [swfm_pkg::CNT_W-1:0]          out_freq_value
);

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = swfm_pkg::CNT_W;
  localparam int unsigned STEP_W = swfm_pkg::STEP_W;
  localparam logic [IDX_W:0]   DEPTH_L = (IDX_W+1)'(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic               meas_en_r, meas_en_nxt;
  logic [15:0]        window_ms_r, window_ms_nxt;
  logic [IDX_W-1:0]   wi_r, wi_nxt;
  logic               ready_r, ready_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic               fv_r, fv_nxt;
  logic [CNT_W-1:0]   sample_r, sample_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]   q_r, q_nxt;
  logic [STEP_W-1:0]  rem_r, rem_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_fv_r, out_fv_nxt;
  logic [CNT_W-1:0]   out_val_r, out_val_nxt;

  logic [15:0]        w_sat;
  logic [23:0]        recip_prod;
  logic [STEP_W-1:0]  step_w;
  logic [IDX_W-1:0]   wi_inc;
  logic [IDX_W:0]     back_diff;
  logic [IDX_W-1:0]   oldest;
  logic [CNT_W-1:0]   rd_data;
  logic               ram_we;
  logic [CNT_W+9:0]   prod_w;
  logic [STEP_W:0]    trial;
  logic [STEP_W:0]    shifted;

  always_comb begin
    w_sat = (window_ms_r < swfm_pkg::WIN_MIN_MS) ? swfm_pkg::WIN_MIN_MS : window_ms_r;
    recip_prod = w_sat[10:0] * swfm_pkg::TICK_RECIP;
    step_w = (w_sat <= swfm_pkg::WIN_CAP_MS) ? recip_prod[23:16] : swfm_pkg::STEP_CAP;
  end

  assign wi_inc = (wi_r == LAST_IDX) ? '0 : wi_r + 1'b1;
  assign back_diff = ({1'b0, wi_r} >= (IDX_W+1)'(step_w))
                   ? {1'b0, wi_r} - (IDX_W+1)'(step_w)
                   : DEPTH_L - (IDX_W+1)'(step_w) + {1'b0, wi_r};
  assign oldest = back_diff[IDX_W-1:0];

  assign in_ready = (state_r == ST_IDLE);
  assign ram_we = in_valid && in_ready && meas_en_r && in_running;

  swfm_ram #(
    .WIDTH(CNT_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wi_r),
    .wdata(in_count_sample),
    .re   (ram_we),
    .raddr(oldest),
    .rdata(rd_data)
  );

  assign prod_w  = q_r * swfm_pkg::FREQ_SCALE;
  assign shifted = {rem_r, q_r[CNT_W-1]};
  assign trial   = shifted - {1'b0, step_r};

  always_comb begin
    state_nxt     = state_r;
    meas_en_nxt   = meas_en_r;
    window_ms_nxt = window_ms_r;
    wi_nxt        = wi_r;
    ready_nxt     = ready_r;
    held_nxt      = held_r;
    fv_nxt        = fv_r;
    sample_nxt    = sample_r;
    step_nxt      = step_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_fv_nxt    = out_fv_r;
    out_val_nxt   = out_val_r;

    if (cfg_we) begin
      case (cfg_index)
        swfm_pkg::REG_MEASURE_ENABLE: meas_en_nxt = cfg_wdata[0];
        swfm_pkg::REG_WINDOW_MS:      window_ms_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          fv_nxt    = 1'b0;
          state_nxt = ST_DONE;
          if (meas_en_r) begin
            if (in_running) begin
              wi_nxt     = wi_inc;
              sample_nxt = in_count_sample;
              step_nxt   = step_w;
              if (ready_r || (wi_inc > IDX_W'(step_w))) begin
                ready_nxt = 1'b1;
                state_nxt = ST_SUB;
              end
            end else begin
              wi_nxt    = '0;
              ready_nxt = 1'b0;
            end
          end
        end
      end
      ST_SUB: begin
        q_nxt     = sample_r - rd_data;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        q_nxt     = prod_w[CNT_W-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!trial[STEP_W]) begin
          rem_nxt = trial[STEP_W-1:0];
        end else begin
          rem_nxt = shifted[STEP_W-1:0];
        end
        q_nxt   = {q_r[CNT_W-2:0], !trial[STEP_W]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          held_nxt  = {q_r[CNT_W-2:0], !trial[STEP_W]};
          fv_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_fv_nxt    = fv_r;
          out_val_nxt   = held_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      meas_en_r   <= 1'b0;
      window_ms_r <= swfm_pkg::WINDOW_MS_RESET;
      wi_r        <= '0;
      ready_r     <= 1'b0;
      held_r      <= '0;
      fv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      meas_en_r   <= meas_en_nxt;
      window_ms_r <= window_ms_nxt;
      wi_r        <= wi_nxt;
      ready_r     <= ready_nxt;
      held_r      <= held_nxt;
      fv_r        <= fv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r  <= sample_nxt;
    step_r    <= step_nxt;
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    out_fv_r  <= out_fv_nxt;
    out_val_r <= out_val_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_freq_valid = out_fv_r;
  assign out_freq_value = out_val_r;

endmodule

// File: bench/tb_sliding_window_frequency_meter_top.sv
// Self-checking testbench for the sliding window frequency meter channel.
// Predicts every result from its own copy of the ring, index and settings.
// Depends on swfm_pkg and sliding_window_frequency_meter_top.
module tb_sliding_window_frequency_meter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING        = 256;
  localparam int unsigned TICK_MS     = 10;
  localparam int unsigned ITEM_TARGET = 850;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned CYCLE_LIMIT = 600_000;

  typedef struct packed {
    logic                       freq_valid;
    logic [swfm_pkg::CNT_W-1:0] freq_value;
  } freq_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [swfm_pkg::CFG_IDX_W-1:0]  cfg_index = swfm_pkg::REG_MEASURE_ENABLE;
  logic [swfm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [swfm_pkg::CNT_W-1:0]      in_count_sample = '0;
  logic                            in_running = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_freq_valid;
  logic [swfm_pkg::CNT_W-1:0]      out_freq_value;

  // predictor state and settings
  logic [swfm_pkg::CNT_W-1:0] count_ring [RING];
  bit                         ring_written [RING];
  int unsigned                wr_pos = 0;
  bit                         window_armed = 1'b0;
  logic [swfm_pkg::CNT_W-1:0] last_freq = '0;
  logic                       meas_en = 1'b0;
  logic [15:0]                win_ms = swfm_pkg::WINDOW_MS_RESET;

  freq_result_t expected_freqs[$];
  int unsigned  burst_left = 0;
  int unsigned  ticks_measured = 0;
  int unsigned  freq_results = 0;
  int unsigned  window_settings = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  logic [swfm_pkg::CNT_W-1:0] stream_count = '0;

  logic     hold_flip = 1'b0;
  logic     hold_seen = 1'b0;
  int       hold_left = 0;
  int       rx_stretch = 0;
  rx_mode_t rx_mode = RX_OPEN;

  sliding_window_frequency_meter_top #(.RING_DEPTH(RING)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_count_sample(in_count_sample),
    .in_running     (in_running),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_freq_valid (out_freq_valid),
    .out_freq_value (out_freq_value)
  );

  always #4 clk = ~clk;

  function automatic int unsigned ticks_per_window();
    logic [15:0] w;
    w = win_ms;
    if (w < swfm_pkg::WIN_MIN_MS) w = swfm_pkg::WIN_MIN_MS;
    if (w <= swfm_pkg::WIN_CAP_MS) return w / TICK_MS;
    return swfm_pkg::STEP_CAP;
  endfunction

  function automatic int unsigned ring_prev(int unsigned pos, int unsigned back);
    return (pos + RING - back) % RING;
  endfunction

  // true when a running tick now would read a ring entry never written
  function automatic bit hits_blank();
    int unsigned span;
    span = ticks_per_window();
    if (!meas_en || !(window_armed || ((wr_pos + 1) % RING) > span)) return 1'b0;
    return !ring_written[ring_prev(wr_pos, span)];
  endfunction

  function automatic freq_result_t predict_tick(logic [swfm_pkg::CNT_W-1:0] cnt, logic run);
    freq_result_t r;
    int unsigned  span;
    int unsigned  newest;
    logic [swfm_pkg::CNT_W-1:0] delta;
    logic [swfm_pkg::CNT_W-1:0] scaled;
    r.freq_valid = 1'b0;
    if (meas_en) begin
      if (run) begin
        count_ring[wr_pos] = cnt;
        ring_written[wr_pos] = 1'b1;
        newest = wr_pos;
        wr_pos = (wr_pos + 1) % RING;
        span = ticks_per_window();
        if (wr_pos > span) window_armed = 1'b1;
        if (window_armed) begin
          delta = count_ring[newest] - count_ring[ring_prev(newest, span)];
          scaled = delta * 32'(swfm_pkg::FREQ_SCALE);
          last_freq = scaled / span;
          r.freq_valid = 1'b1;
        end
      end else begin
        wr_pos = 0;
        window_armed = 1'b0;
      end
    end
    r.freq_value = last_freq;
    return r;
  endfunction

  task automatic send_tick(input logic [swfm_pkg::CNT_W-1:0] cnt, input logic run);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 12) : 1;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    in_valid <= 1'b1;
    in_count_sample <= cnt;
    in_running <= run;
    do @(posedge clk); while (!in_ready);
    if (meas_en) ticks_measured++;
    expected_freqs.push_back(predict_tick(cnt, run));
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
    while (expected_freqs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [swfm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swfm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == swfm_pkg::REG_MEASURE_ENABLE) begin
      meas_en = val[0];
    end else begin
      win_ms = val;
      window_settings++;
    end
  endtask

  task automatic set_enable(input logic en);
    cfg_write(swfm_pkg::REG_MEASURE_ENABLE, {15'($urandom), en});
  endtask

  task automatic test_disabled_after_reset();
    send_tick(32'hFFFF_FFFF, 1'b1);
    send_tick(32'h0000_0000, 1'b0);
    send_tick(32'h8000_0001, 1'b1);
    drain_results();
  endtask

  task automatic test_default_window();
    logic [swfm_pkg::CNT_W-1:0] rate;
    rate = $urandom_range(1, 5000);
    stream_count = $urandom;
    set_enable(1'b1);
    repeat (103) begin
      stream_count += rate;
      send_tick(stream_count, 1'b1);
    end
    drain_results();
  endtask

  task automatic test_short_window();
    cfg_write(swfm_pkg::REG_WINDOW_MS, 16'd0);
    send_tick(32'h1234_5678, 1'b0);
    send_tick(32'h0000_0000, 1'b1);
    send_tick(32'hFFFF_FFFF, 1'b1);
    send_tick(32'h0000_0000, 1'b1);
    send_tick(32'h0041_8937, 1'b1);
    drain_results();
    cfg_write(swfm_pkg::REG_WINDOW_MS, 16'd9);
    send_tick(32'h0041_8938, 1'b1);
    drain_results();
  endtask

  task automatic test_stop_and_disable();
    send_tick(32'd5, 1'b0);
    send_tick(32'd100, 1'b1);
    send_tick(32'd150, 1'b1);
    drain_results();
    set_enable(1'b0);
    send_tick(32'd999, 1'b1);
    send_tick(32'd7, 1'b0);
    drain_results();
    set_enable(1'b1);
    send_tick(32'd160, 1'b1);
    drain_results();
  endtask

  task automatic test_window_grow();
    cfg_write(swfm_pkg::REG_WINDOW_MS, 16'd20);
    send_tick(32'd0, 1'b0);
    for (int i = 0; i < 6; i++) send_tick(32'd1000 + 32'(i * 37), 1'b1);
    drain_results();
    cfg_write(swfm_pkg::REG_WINDOW_MS, 16'd50);
    for (int i = 6; i < 9; i++) send_tick(32'd1000 + 32'(i * 41), 1'b1);
    drain_results();
  endtask

  task automatic test_backpressure();
    cfg_write(swfm_pkg::REG_WINDOW_MS, 16'd30);
    hold_flip <= ~hold_flip;
    repeat (8) begin
      stream_count += $urandom_range(0, 70000);
      send_tick(stream_count, !hits_blank());
    end
    drain_results();
  endtask

  task automatic test_random_windows();
    logic [15:0]                extremes[4];
    logic [15:0]                w;
    logic [swfm_pkg::CNT_W-1:0] rate;
    int unsigned                phase;
    int unsigned                span;
    int unsigned                len;
    extremes = '{16'd0, 16'd65535, 16'd2000, 16'd19};
    phase = 0;
    while (ticks_measured < ITEM_TARGET) begin
      drain_results();
      if (phase < 4) begin
        w = extremes[phase];
      end else begin
        case ($urandom_range(0, 19))
          0: w = 16'($urandom);
          1, 2: w = 16'($urandom_range(0, 9));
          default: w = 16'($urandom_range(10, 400));
        endcase
      end
      cfg_write(swfm_pkg::REG_WINDOW_MS, w);
      if (phase >= 4 && $urandom_range(0, 9) == 0) begin
        set_enable(1'b0);
        repeat ($urandom_range(2, 6)) send_tick($urandom, 1'($urandom));
        phase++;
        continue;
      end
      set_enable(1'b1);
      case ($urandom_range(0, 4))
        0: rate = 0;
        1: rate = $urandom_range(1, 50);
        2: rate = $urandom_range(1000, 100000);
        3: rate = $urandom;
        default: rate = $urandom_range(4_000_000, 5_000_000);
      endcase
      span = ticks_per_window();
      len = span + ((phase == 1) ? $urandom_range(60, 80) : $urandom_range(4, 30));
      if ($urandom_range(0, 1) == 0) send_tick($urandom, 1'b0);
      for (int i = 0; i < len; i++) begin
        stream_count += rate + $urandom_range(0, 3);
        if (span < 30 && $urandom_range(0, 29) == 0) send_tick($urandom, 1'b0);
        else if ($urandom_range(0, 19) == 0) send_tick($urandom, !hits_blank());
        else send_tick(stream_count, !hits_blank());
      end
      phase++;
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    if (hold_flip != hold_seen) begin
      hold_seen <= hold_flip;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_stretch == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_stretch <= $urandom_range(20, 200);
      end else begin
        rx_stretch <= rx_stretch - 1;
      end
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  always @(posedge clk) begin
    freq_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_freqs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual freq_valid %0b freq_value %0d",
                 $time, out_freq_valid, out_freq_value);
        mismatches++;
      end else begin
        want = expected_freqs.pop_front();
        if (out_freq_valid !== want.freq_valid) begin
          $display("%0t: freq_valid expected %0b actual %0b",
                   $time, want.freq_valid, out_freq_valid);
          mismatches++;
        end
        if (out_freq_value !== want.freq_value) begin
          $display("%0t: freq_value expected %0d actual %0d",
                   $time, want.freq_value, out_freq_value);
          mismatches++;
        end
        if (want.freq_valid) freq_results++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_freqs.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled_after_reset();
    test_default_window();
    test_short_window();
    test_stop_and_disable();
    test_window_grow();
    test_backpressure();
    test_random_windows();
    repeat (50) @(posedge clk);
    $display("Covered %0d measured ticks and %0d frequencies over %0d window settings,",
             ticks_measured, freq_results, window_settings);
    $display("with stops, disabled ticks, ring wrap, count wrap and output backpressure.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
design/swfm_pkg.sv
design/swfm_ram.sv
design/sliding_window_frequency_meter_top.sv
bench/tb_sliding_window_frequency_meter_top.sv
